[hdl/wsd_pkg.sv]
// wav stream decoder package: phase encoding, result codes, result record
// and the float32 to q0.23 conversion; no dependencies
package wsd_pkg;

    typedef enum logic [6:0] {
        PH_RIFF = 7'b0000001,
        PH_HDR  = 7'b0000010,
        PH_FMT  = 7'b0000100,
        PH_SKIP = 7'b0001000,
        PH_PAD  = 7'b0010000,
        PH_DATA = 7'b0100000,
        PH_END  = 7'b1000000
    } t_phase;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NOT_RIFF  = 4'd1;
    localparam logic [3:0] ERR_FMT_SMALL = 4'd2;
    localparam logic [3:0] ERR_NO_FMT    = 4'd3;
    localparam logic [3:0] ERR_FORMAT    = 4'd4;
    localparam logic [3:0] ERR_CHANNELS  = 4'd5;
    localparam logic [3:0] ERR_DEPTH     = 4'd6;
    localparam logic [3:0] ERR_ALIGN     = 4'd7;
    localparam logic [3:0] ERR_VARIANT   = 4'd8;
    localparam logic [3:0] ERR_EMPTY     = 4'd9;
    localparam logic [3:0] ERR_TRUNC     = 4'd10;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [3:0]         error_code;
        logic [31:0]        frame_count;
        logic [1:0]         channel_count;
        logic [31:0]        sample_rate;
        logic signed [23:0] right_sample;
        logic signed [23:0] left_sample;
        logic [1:0]         kind;
    } t_result;

    function automatic logic [23:0] float_to_q23(input logic [31:0] bits);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [7:0]  sh;
        logic [23:0] mag;
        logic [23:0] res;
        sgn = bits[31];
        ex  = bits[30:23];
        man = bits[22:0];
        sh  = 8'd127 - ex;
        mag = {1'b1, man} >> sh[4:0];
        if (ex == 8'hFF) begin
            res = (man != 23'd0) ? 24'd0 : (sgn ? 24'h800000 : 24'h7FFFFF);
        end else if (ex == 8'd0) begin
            res = 24'd0;
        end else if (ex >= 8'd127) begin
            res = sgn ? 24'h800000 : 24'h7FFFFF;
        end else if (sh >= 8'd24) begin
            res = 24'd0;
        end else begin
            res = sgn ? (24'd0 - mag) : mag;
        end
        return res;
    endfunction

endpackage

[hdl/wav_stream_decoder_unit.sv]
// wav stream decoder top level: byte-serial riff/wave parser with a small
// result queue; depends on wsd_pkg
// results are written to the queue at the edge that accepts their byte and
// are offered from the next cycle
// throughput: one byte per cycle while the 4-entry result queue has room for
// two results (an item makes at most two); input stalls once three results wait
// reset: i_rst_n synchronous active low; clears the parser and empties the queue
module wav_stream_decoder_unit
    import wsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // in_byte
    input  logic         i_s_tlast,   // last
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // left_sample, right_sample, sample_rate, channel_count, frame_count,
    // error_code, zero fill
    output logic [119:0] o_m_tdata,
    output logic [1:0]   o_m_tuser    // kind
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_len, n_len;
    logic [31:0] r_tag, n_tag;
    logic [15:0] r_afmt, n_afmt;
    logic [15:0] r_nch, n_nch;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_align, n_align;
    logic [15:0] r_depth, n_depth;
    logic        r_fmt_seen, n_fmt_seen;
    logic [15:0] r_fidx, n_fidx;
    logic [63:0] r_fbytes, n_fbytes;
    logic [31:0] r_frames, n_frames;

    t_result             r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_qcnt;

    t_result     res0, res1;
    logic [1:0]  nres;
    logic        accept, pop;
    logic [7:0]  b;
    logic [3:0]  derr;
    logic [3:0]  need;
    logic [63:0] fcur;
    logic [23:0] dl, dr;

    assign accept = i_s_tvalid && o_s_tready;
    assign pop    = o_m_tvalid && i_m_tready;
    assign b      = i_s_tdata;
    assign o_s_tready = (r_qcnt <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
    assign o_m_tvalid = (r_qcnt != '0);
    assign o_m_tuser  = r_q[r_rp].kind;
    assign o_m_tdata  = {2'b00, r_q[r_rp].error_code, r_q[r_rp].frame_count,
                         r_q[r_rp].channel_count, r_q[r_rp].sample_rate,
                         r_q[r_rp].right_sample, r_q[r_rp].left_sample};

    // data chunk checks in priority order; the length includes its final byte
    always_comb begin
        need = (r_nch[1:0] == 2'd2) ? {r_depth[5:3], 1'b0} : {1'b0, r_depth[5:3]};
        if (!r_fmt_seen)                                  derr = ERR_NO_FMT;
        else if (r_afmt != FMT_PCM && r_afmt != FMT_FLOAT) derr = ERR_FORMAT;
        else if (r_nch != 16'd1 && r_nch != 16'd2)         derr = ERR_CHANNELS;
        else if (r_depth != 16'd16 && r_depth != 16'd24 && r_depth != 16'd32)
                                                          derr = ERR_DEPTH;
        else if (r_align == 16'd0 || r_align < {12'd0, need})
                                                          derr = ERR_ALIGN;
        else if ({b, r_len[23:0]} < {16'd0, r_align})     derr = ERR_EMPTY;
        else if (r_afmt == FMT_PCM && r_depth == 16'd32)  derr = ERR_VARIANT;
        else if (r_afmt == FMT_FLOAT && r_depth != 16'd32) derr = ERR_VARIANT;
        else                                              derr = ERR_NONE;
    end

    // frame bytes including the byte of this item, decoded to left and right samples
    always_comb begin
        fcur = r_fbytes;
        if (r_fidx < 16'd8) fcur[r_fidx[2:0]*8 +: 8] = b;
        if (r_afmt == FMT_FLOAT) begin
            dl = float_to_q23(fcur[31:0]);
            dr = float_to_q23(fcur[63:32]);
        end else if (r_depth == 16'd16) begin
            dl = {fcur[15:0], 8'd0};
            dr = {fcur[31:16], 8'd0};
        end else begin
            dl = fcur[23:0];
            dr = fcur[47:24];
        end
        if (r_nch != 16'd2) dr = 24'd0;
    end

    always_comb begin
        t_result rz;
        logic    v_err, v_frame, v_done, v_trunc;
        logic [3:0] ecode;
        rz = '0;
        n_phase = r_phase; n_cnt = r_cnt; n_len = r_len; n_tag = r_tag;
        n_afmt = r_afmt; n_nch = r_nch; n_rate = r_rate; n_align = r_align;
        n_depth = r_depth; n_fmt_seen = r_fmt_seen; n_fidx = r_fidx;
        n_fbytes = r_fbytes; n_frames = r_frames;
        v_err = 1'b0; v_frame = 1'b0; v_done = 1'b0; v_trunc = 1'b0;
        ecode = ERR_NONE;
        res0 = rz; res1 = rz; nres = 2'd0;

        unique case (r_phase)
            PH_RIFF: begin
                if (r_cnt < 32'd4 || r_cnt >= 32'd8) n_tag = {r_tag[23:0], b};
                if ((r_cnt == 32'd3 && n_tag != TAG_RIFF) ||
                    (r_cnt == 32'd11 && n_tag != TAG_WAVE)) begin
                    v_err = 1'b1; ecode = ERR_NOT_RIFF; n_phase = PH_END;
                end else if (r_cnt == 32'd11) begin
                    n_cnt = '0; n_phase = PH_HDR;
                end else begin
                    n_cnt = r_cnt + 32'd1;
                end
            end
            PH_HDR: begin
                if (r_cnt < 32'd4) begin
                    n_tag = {r_tag[23:0], b};
                    if (r_cnt == 32'd0) n_len = '0;
                end else begin
                    unique case (r_cnt[1:0])
                        2'd0: n_len[7:0]   = b;
                        2'd1: n_len[15:8]  = b;
                        2'd2: n_len[23:16] = b;
                        2'd3: n_len[31:24] = b;
                        default: ;
                    endcase
                end
                if (r_cnt < 32'd7) begin
                    n_cnt = r_cnt + 32'd1;
                end else begin
                    n_cnt = '0;
                    if (n_tag == TAG_FMT) begin
                        if (n_len < FMT_MIN_LEN) begin
                            v_err = 1'b1; ecode = ERR_FMT_SMALL; n_phase = PH_END;
                        end else begin
                            n_phase = PH_FMT;
                        end
                    end else if (n_tag == TAG_DATA) begin
                        if (derr != ERR_NONE) begin
                            v_err = 1'b1; ecode = derr; n_phase = PH_END;
                        end else begin
                            n_fidx = '0; n_fbytes = '0; n_frames = '0;
                            n_phase = PH_DATA;
                        end
                    end else if (n_len == 32'd0) begin
                        n_phase = PH_HDR;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_FMT: begin
                if (r_cnt < 32'd16) begin
                    unique case (r_cnt[3:0])
                        4'd0:  n_afmt[7:0]   = b;
                        4'd1:  n_afmt[15:8]  = b;
                        4'd2:  n_nch[7:0]    = b;
                        4'd3:  n_nch[15:8]   = b;
                        4'd4:  n_rate[7:0]   = b;
                        4'd5:  n_rate[15:8]  = b;
                        4'd6:  n_rate[23:16] = b;
                        4'd7:  n_rate[31:24] = b;
                        4'd12: n_align[7:0]  = b;
                        4'd13: n_align[15:8] = b;
                        4'd14: n_depth[7:0]  = b;
                        4'd15: n_depth[15:8] = b;
                        default: ;
                    endcase
                end
                if (r_cnt + 32'd1 == r_len) begin
                    n_fmt_seen = 1'b1; n_cnt = '0;
                    n_phase = r_len[0] ? PH_PAD : PH_HDR;
                end else begin
                    n_cnt = r_cnt + 32'd1;
                end
            end
            PH_SKIP: begin
                if (r_cnt + 32'd1 == r_len) begin
                    n_cnt = '0; n_phase = r_len[0] ? PH_PAD : PH_HDR;
                end else begin
                    n_cnt = r_cnt + 32'd1;
                end
            end
            PH_PAD: begin
                n_cnt = '0; n_phase = PH_HDR;
            end
            PH_DATA: begin
                n_fbytes = fcur;
                n_fidx = r_fidx + 16'd1;
                if (n_fidx == r_align) begin
                    v_frame = 1'b1;
                    n_frames = r_frames + 32'd1;
                end
                if (r_cnt + 32'd1 == r_len) begin
                    v_done = 1'b1; n_phase = PH_END;
                end else begin
                    n_cnt = r_cnt + 32'd1;
                end
            end
            PH_END: ;
            default: n_phase = PH_END;
        endcase

        v_trunc = i_s_tlast && (n_phase != PH_END);

        // pack up to two results in order
        if (v_err) begin
            res0.kind = KIND_ERROR; res0.error_code = ecode; nres = 2'd1;
        end else if (v_frame) begin
            res0.kind = KIND_FRAME; res0.left_sample = dl;
            res0.right_sample = dr; nres = 2'd1;
        end
        if (v_done) begin
            if (nres == 2'd0) begin
                res0.kind = KIND_DONE; res0.sample_rate = r_rate;
                res0.channel_count = r_nch[1:0]; res0.frame_count = n_frames;
            end else begin
                res1.kind = KIND_DONE; res1.sample_rate = r_rate;
                res1.channel_count = r_nch[1:0]; res1.frame_count = n_frames;
            end
            nres = nres + 2'd1;
        end
        if (v_trunc) begin
            if (nres == 2'd0) begin
                res0.kind = KIND_ERROR; res0.error_code = ERR_TRUNC;
            end else begin
                res1.kind = KIND_ERROR; res1.error_code = ERR_TRUNC;
            end
            nres = nres + 2'd1;
        end

        if (v_frame) begin
            n_fidx = '0; n_fbytes = '0;
        end

        if (i_s_tlast) begin
            n_phase = PH_RIFF; n_cnt = '0; n_len = '0; n_tag = '0;
            n_afmt = '0; n_nch = '0; n_rate = '0; n_align = '0; n_depth = '0;
            n_fmt_seen = 1'b0; n_fidx = '0; n_fbytes = '0; n_frames = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF; r_cnt <= '0; r_len <= '0; r_tag <= '0;
            r_afmt <= '0; r_nch <= '0; r_rate <= '0; r_align <= '0;
            r_depth <= '0; r_fmt_seen <= 1'b0; r_fidx <= '0;
            r_fbytes <= '0; r_frames <= '0;
        end else if (accept) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_len <= n_len; r_tag <= n_tag;
            r_afmt <= n_afmt; r_nch <= n_nch; r_rate <= n_rate; r_align <= n_align;
            r_depth <= n_depth; r_fmt_seen <= n_fmt_seen; r_fidx <= n_fidx;
            r_fbytes <= n_fbytes; r_frames <= n_frames;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (accept && nres != 2'd0) r_q[r_wp] <= res0;
        if (accept && nres == 2'd2) r_q[r_wp + QUEUE_AW'(1)] <= res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_qcnt <= '0;
        end else begin
            if (accept) r_wp <= r_wp + QUEUE_AW'(accept ? nres : 2'd0);
            if (pop) r_rp <= r_rp + QUEUE_AW'(1);
            r_qcnt <= r_qcnt + (QUEUE_AW + 1)'(accept ? nres : 2'd0)
                             - (QUEUE_AW + 1)'(pop);
        end
    end

endmodule
